// ===== sv/wpf_pkg.sv =====
package wpf_pkg;

  localparam int DEFAULT_MAX_DIM = 4096;

  localparam int PIXEL_W    = 32;
  localparam int DIM_W      = 13;
  localparam int OFFSET_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(100);

  localparam logic [PIXEL_W-1:0] GREY_COLOUR = 32'h00CC_CCCC;
  localparam logic [PIXEL_W-1:0] ALPHA_FULL  = 32'hFF00_0000;

  // floor(sum / 3) for sum <= 765: (sum * 683) >> 11
  localparam logic [9:0] AVG_RECIP = 10'd683;
  localparam int         AVG_SHIFT = 11;
  localparam logic [7:0] SNAP_LEVEL = 8'd128;
  localparam logic [7:0] CHAN_FULL  = 8'd255;

  typedef enum logic [2:0] {
    MODE_PASS   = 3'd0,
    MODE_RED    = 3'd1,
    MODE_GREEN  = 3'd2,
    MODE_BLUE   = 3'd3,
    MODE_GRAY   = 3'd4,
    MODE_THRESH = 3'd5,
    MODE_POSTER = 3'd6,
    MODE_TOP    = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X   = 3'd0,
    REG_OFFSET_Y   = 3'd1,
    REG_FILTER     = 3'd2,
    REG_SRC_WIDTH  = 3'd3,
    REG_SRC_HEIGHT = 3'd4,
    REG_DST_WIDTH  = 3'd5,
    REG_DST_HEIGHT = 3'd6
  } cfg_idx_t;

endpackage

// ===== sv/wpf_colour.sv =====
module wpf_colour (
  input  logic [wpf_pkg::PIXEL_W-1:0] src,
  input  wpf_pkg::mode_t              mode,
  output logic [wpf_pkg::PIXEL_W-1:0] colour
);

  logic [wpf_pkg::PIXEL_W-1:0] rgb;
  logic [7:0]  r, g, b;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  avg, avg_snap, r_snap, g_snap, b_snap;

  assign rgb  = src - wpf_pkg::ALPHA_FULL;
  assign r    = rgb[7:0];
  assign g    = rgb[15:8];
  assign b    = rgb[23:16];
  assign sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
  assign prod = {10'd0, sum} * {10'd0, wpf_pkg::AVG_RECIP};
  assign avg  = prod[wpf_pkg::AVG_SHIFT+7:wpf_pkg::AVG_SHIFT];

  assign avg_snap = (avg >= wpf_pkg::SNAP_LEVEL) ? wpf_pkg::CHAN_FULL : 8'd0;
  assign r_snap   = (r   >= wpf_pkg::SNAP_LEVEL) ? wpf_pkg::CHAN_FULL : 8'd0;
  assign g_snap   = (g   >= wpf_pkg::SNAP_LEVEL) ? wpf_pkg::CHAN_FULL : 8'd0;
  assign b_snap   = (b   >= wpf_pkg::SNAP_LEVEL) ? wpf_pkg::CHAN_FULL : 8'd0;

  always_comb begin
    case (mode)
      wpf_pkg::MODE_PASS:   colour = rgb;
      wpf_pkg::MODE_RED:    colour = {24'd0, r};
      wpf_pkg::MODE_GREEN:  colour = {16'd0, g, 8'd0};
      wpf_pkg::MODE_BLUE:   colour = {8'd0, b, 16'd0};
      wpf_pkg::MODE_GRAY:   colour = {8'd0, avg, avg, avg};
      wpf_pkg::MODE_THRESH: colour = {8'd0, avg_snap, avg_snap, avg_snap};
      wpf_pkg::MODE_POSTER: colour = {8'd0, b_snap, g_snap, r_snap};
      default:              colour = {rgb[31:24], 24'd0};
    endcase
  end

endmodule

// ===== sv/windowed_pixel_filter_top.sv =====
// Windowed pixel filter. Takes one target pixel per transfer in raster order;
// s_axis_tdata carries the source word fetched for the mapped position and
// the target word that supplies alpha. The source position is the internal
// column/row count plus the signed offsets; outside the source image the
// colour is grey, inside it the source colour is filtered by filter_mode;
// either is added to the target word. Throughput is one pixel per clock
// unless the output stalls. An input register (which also takes the bounds
// test and raster count) is followed by a result register holding the
// filtered pixel, so a result held on a stalled output does not stop the
// next input transfer while the input register is free. tlast marks the last
// pixel of the target frame, tuser the in-bounds flag. Configuration writes
// are always accepted and should only be issued while the pipeline is empty.
module windowed_pixel_filter_top #(
  parameter int MAX_DIM = wpf_pkg::DEFAULT_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] src_pixel, [63:32] target_word

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] out_pixel
  output logic        m_axis_tlast,   // last_pixel
  output logic        m_axis_tuser,   // [0] in_bounds

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wpf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = (CW + 1 > wpf_pkg::DIM_W) ? CW + 1 : wpf_pkg::DIM_W;
  localparam int SW = ((CW > wpf_pkg::OFFSET_W) ? CW : wpf_pkg::OFFSET_W) + 2;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_DIM);

  // configuration
  logic signed [wpf_pkg::OFFSET_W-1:0] offset_x, offset_y;
  wpf_pkg::mode_t                      filter_mode;
  logic [wpf_pkg::DIM_W-1:0]           src_width, src_height, dst_width, dst_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      filter_mode <= wpf_pkg::MODE_PASS;
      src_width   <= wpf_pkg::DIM_RESET;
      src_height  <= wpf_pkg::DIM_RESET;
      dst_width   <= wpf_pkg::DIM_RESET;
      dst_height  <= wpf_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (wpf_pkg::cfg_idx_t'(cfg_index))
        wpf_pkg::REG_OFFSET_X:   offset_x    <= $signed(cfg_data);
        wpf_pkg::REG_OFFSET_Y:   offset_y    <= $signed(cfg_data);
        wpf_pkg::REG_FILTER:     filter_mode <= wpf_pkg::mode_t'(cfg_data[2:0]);
        wpf_pkg::REG_SRC_WIDTH:  src_width   <= cfg_data[wpf_pkg::DIM_W-1:0];
        wpf_pkg::REG_SRC_HEIGHT: src_height  <= cfg_data[wpf_pkg::DIM_W-1:0];
        wpf_pkg::REG_DST_WIDTH:  dst_width   <= cfg_data[wpf_pkg::DIM_W-1:0];
        wpf_pkg::REG_DST_HEIGHT: dst_height  <= cfg_data[wpf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position and bounds test, evaluated at input transfer
  logic [CW-1:0] col, row, col_next, row_next;
  logic [EW-1:0] w_eff, h_eff, dw_ext, dh_ext, col_inc, row_inc;
  logic          end_col, end_row, in_fire, in_inside, in_last;
  logic signed [SW-1:0] sx, sy;

  assign dw_ext = EW'(dst_width);
  assign dh_ext = EW'(dst_height);

  always_comb begin
    if (dst_width == '0)     w_eff = EW'(1);
    else if (dw_ext > MAX_E) w_eff = MAX_E;
    else                     w_eff = dw_ext;
    if (dst_height == '0)    h_eff = EW'(1);
    else if (dh_ext > MAX_E) h_eff = MAX_E;
    else                     h_eff = dh_ext;
  end

  assign col_inc = EW'(col) + EW'(1);
  assign row_inc = EW'(row) + EW'(1);
  assign end_col = col_inc >= w_eff;
  assign end_row = row_inc >= h_eff;
  assign in_last = end_col && end_row;

  always_comb begin
    col_next = col;
    row_next = row;
    if (end_col) begin
      col_next = '0;
      row_next = end_row ? '0 : row_inc[CW-1:0];
    end else begin
      col_next = col_inc[CW-1:0];
    end
  end

  assign sx = $signed(SW'(col)) + SW'(offset_x);
  assign sy = $signed(SW'(row)) + SW'(offset_y);
  assign in_inside = !sx[SW-1] && (sx < $signed(SW'(src_width))) &&
                     !sy[SW-1] && (sy < $signed(SW'(src_height)));

  // pipeline control
  logic v1, v2, s2_ready;
  assign s2_ready      = !v2 || m_axis_tready;
  assign s_axis_tready = !v1 || s2_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // input register
  logic [31:0] src1, tgt1;
  logic        inside1, last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_axis_tready) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      src1    <= s_axis_tdata[31:0];
      tgt1    <= s_axis_tdata[63:32];
      inside1 <= in_inside;
      last1   <= in_last;
    end
  end

  logic [31:0] filt_colour, colour;

  wpf_colour u_colour (
    .src    (src1),
    .mode   (filter_mode),
    .colour (filt_colour)
  );

  assign colour = inside1 ? filt_colour : wpf_pkg::GREY_COLOUR;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_ready) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && v1) begin
      m_axis_tdata <= tgt1 + colour;
      m_axis_tuser <= inside1;
      m_axis_tlast <= last1;
    end
  end

  assign m_axis_tvalid = v2;

  // checks
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (v1 && v2))
    else $error("input stalled with a free pipeline stage");

  a_wrap_on_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_last) |=> (col == '0 && row == '0))
    else $error("raster count did not wrap after last pixel");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !end_col) |=> (col == $past(col) + CW'(1) && row == $past(row)))
    else $error("column count did not advance by one");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !s2_ready) |=> (v1 && $stable(tgt1) && $stable(inside1)))
    else $error("input register changed while result stalled");

endmodule

// ===== tb/windowed_pixel_filter_top_tb.sv =====
`timescale 1ns / 100ps

module windowed_pixel_filter_top_tb;

  localparam int FRAME_MAX = wpf_pkg::DEFAULT_MAX_DIM;

  typedef struct packed {
    logic [31:0] pixel;
    logic        in_src;
    logic        last_pix;
  } pixel_result_t;

  class pixel_scoreboard;
    logic signed [15:0] off_x, off_y;
    wpf_pkg::mode_t     mode;
    logic [12:0]        src_w, src_h, dst_w, dst_h;
    int                 col, row;
    pixel_result_t      pending_pixels[$];
    int                 errors, checked, frame_ends, in_bounds_seen;

    function new();
      off_x = '0;
      off_y = '0;
      mode = wpf_pkg::MODE_PASS;
      src_w = wpf_pkg::DIM_RESET;
      src_h = wpf_pkg::DIM_RESET;
      dst_w = wpf_pkg::DIM_RESET;
      dst_h = wpf_pkg::DIM_RESET;
      col = 0;
      row = 0;
    endfunction

    function void apply_config(wpf_pkg::cfg_idx_t idx, logic [15:0] value);
      case (idx)
        wpf_pkg::REG_OFFSET_X:   off_x = value;
        wpf_pkg::REG_OFFSET_Y:   off_y = value;
        wpf_pkg::REG_FILTER:     mode = wpf_pkg::mode_t'(value[2:0]);
        wpf_pkg::REG_SRC_WIDTH:  src_w = value[12:0];
        wpf_pkg::REG_SRC_HEIGHT: src_h = value[12:0];
        wpf_pkg::REG_DST_WIDTH:  dst_w = value[12:0];
        wpf_pkg::REG_DST_HEIGHT: dst_h = value[12:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything above the frame limit is clamped
    function int frame_dim(logic [12:0] d);
      if (d == 0) return 1;
      if (int'(d) > FRAME_MAX) return FRAME_MAX;
      return int'(d);
    endfunction

    function logic [7:0] snap(logic [7:0] v);
      return (v < wpf_pkg::SNAP_LEVEL) ? 8'd0 : wpf_pkg::CHAN_FULL;
    endfunction

    function logic [31:0] filtered_colour(logic [31:0] src);
      logic [31:0] rgb;
      logic [7:0]  r, g, b, avg, lvl;
      logic [9:0]  sum;
      rgb = src - wpf_pkg::ALPHA_FULL;
      r = rgb[7:0];
      g = rgb[15:8];
      b = rgb[23:16];
      sum = 10'(r) + 10'(g) + 10'(b);
      avg = 8'(sum / 3);
      lvl = snap(avg);
      case (mode)
        wpf_pkg::MODE_PASS:   return rgb;
        wpf_pkg::MODE_RED:    return {24'h0, r};
        wpf_pkg::MODE_GREEN:  return {16'h0, g, 8'h0};
        wpf_pkg::MODE_BLUE:   return {8'h0, b, 16'h0};
        wpf_pkg::MODE_GRAY:   return {8'h0, avg, avg, avg};
        wpf_pkg::MODE_THRESH: return {8'h0, lvl, lvl, lvl};
        wpf_pkg::MODE_POSTER: return {8'h0, snap(b), snap(g), snap(r)};
        default:              return {rgb[31:24], 24'h0};
      endcase
    endfunction

    function void note_input(logic [31:0] src, logic [31:0] tgt);
      pixel_result_t exp_pix;
      int  w, h, sx, sy;
      logic end_col, end_row;
      w = frame_dim(dst_w);
      h = frame_dim(dst_h);
      sx = col + int'(off_x);
      sy = row + int'(off_y);
      exp_pix.in_src = (sx >= 0) && (sx < int'(src_w)) && (sy >= 0) && (sy < int'(src_h));
      end_col = (col + 1 >= w);
      end_row = (row + 1 >= h);
      exp_pix.pixel = tgt + (exp_pix.in_src ? filtered_colour(src) : wpf_pkg::GREY_COLOUR);
      exp_pix.last_pix = end_col && end_row;
      pending_pixels.push_back(exp_pix);
      if (end_col) begin
        col = 0;
        row = end_row ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_result(logic [31:0] pixel, logic in_src, logic last_pix);
      pixel_result_t exp_pix;
      if (pending_pixels.size() == 0) begin
        if (errors < 10)
          $display("%0t: result %h in_bounds %b last %b with nothing expected",
                   $realtime, pixel, in_src, last_pix);
        errors++;
        return;
      end
      exp_pix = pending_pixels.pop_front();
      if (pixel !== exp_pix.pixel || in_src !== exp_pix.in_src ||
          last_pix !== exp_pix.last_pix) begin
        if (errors < 10)
          $display("%0t: pixel %0d expected %h in_bounds %b last %b, got %h %b %b",
                   $realtime, checked, exp_pix.pixel, exp_pix.in_src, exp_pix.last_pix,
                   pixel, in_src, last_pix);
        errors++;
      end
      checked++;
      if (exp_pix.last_pix) frame_ends++;
      if (exp_pix.in_src) in_bounds_seen++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [wpf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wpf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  int send_idle_pct = 10;
  int recv_idle_pct = 70;
  int phases_run = 0;

  windowed_pixel_filter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // results are checked before the same edge's input transfer is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (cfg_valid && cfg_ready)
        sb.apply_config(wpf_pkg::cfg_idx_t'(cfg_index), cfg_data);
    end
  end

  task automatic send_pixel(input logic [31:0] src, input logic [31:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tgt, src};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [31:0] src, tgt;
    src = $urandom;
    tgt = $urandom;
    // a full top byte leaves a clean colour after the alpha subtraction
    if ($urandom_range(0, 2) == 0) src[31:24] = 8'hFF;
    if ($urandom_range(0, 3) == 0) tgt[23:0] = 24'h0;
    send_pixel(src, tgt);
  endtask

  task automatic wait_pipeline_empty();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input wpf_pkg::cfg_idx_t idx, input logic [15:0] value);
    wait_pipeline_empty();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic randomize_config();
    logic [15:0] value;
    int          pick;
    for (int i = 0; i <= int'(wpf_pkg::REG_DST_HEIGHT); i++) begin
      if ($urandom_range(0, 1) == 1) begin
        pick = $urandom_range(0, 9);
        case (wpf_pkg::cfg_idx_t'(i))
          wpf_pkg::REG_OFFSET_X, wpf_pkg::REG_OFFSET_Y:
            value = (pick == 0) ? 16'($urandom_range(0, 65535))
                                : 16'($urandom_range(0, 20)) - 16'd10;
          wpf_pkg::REG_FILTER:
            value = 16'($urandom_range(0, 7));
          wpf_pkg::REG_SRC_WIDTH, wpf_pkg::REG_SRC_HEIGHT:
            value = (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'($urandom_range(1, 8191)) : 16'($urandom_range(1, 12));
          default:
            value = (pick == 0) ? 16'd0 :
                    (pick == 1) ? 16'($urandom_range(4097, 8191)) : 16'($urandom_range(1, 8));
        endcase
        write_reg(wpf_pkg::cfg_idx_t'(i), value);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration, all-zero and all-one words
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // every mode on channels straddling the snap level; the second word
    // leaves a nonzero top byte after the alpha subtraction
    for (int m = 0; m < 8; m++) begin
      write_reg(wpf_pkg::REG_FILTER, 16'(m));
      send_pixel(32'hFF80_807F, $urandom);
      send_pixel(32'h0080_8080, $urandom);
    end

    // offset extremes and empty source images are all out of bounds
    write_reg(wpf_pkg::REG_OFFSET_X, 16'h8000);
    send_pixel($urandom, $urandom);
    write_reg(wpf_pkg::REG_OFFSET_X, 16'h7FFF);
    write_reg(wpf_pkg::REG_OFFSET_Y, 16'h8000);
    send_pixel($urandom, $urandom);
    write_reg(wpf_pkg::REG_OFFSET_X, 16'h0000);
    write_reg(wpf_pkg::REG_OFFSET_Y, 16'h7FFF);
    send_pixel($urandom, $urandom);
    write_reg(wpf_pkg::REG_OFFSET_Y, 16'h0000);
    write_reg(wpf_pkg::REG_SRC_WIDTH, 16'd0);
    send_pixel($urandom, $urandom);
    write_reg(wpf_pkg::REG_SRC_WIDTH, 16'd100);
    write_reg(wpf_pkg::REG_SRC_HEIGHT, 16'd0);
    send_pixel($urandom, $urandom);
    write_reg(wpf_pkg::REG_SRC_HEIGHT, 16'd100);

    // shrink the frame below the current column; zero height acts as one
    write_reg(wpf_pkg::REG_DST_WIDTH, 16'd5);
    write_reg(wpf_pkg::REG_DST_HEIGHT, 16'd0);
    repeat (3) send_pixel($urandom, $urandom);

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 10;
      end
      if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      randomize_config();
      repeat ($urandom_range(20, 35)) send_random_pixel();
      phases_run++;
    end

    // oversized frames with source sizes above the frame limit: a clamped
    // wide single line, then a tall single column
    write_reg(wpf_pkg::REG_SRC_WIDTH, 16'd8191);
    write_reg(wpf_pkg::REG_SRC_HEIGHT, 16'd8191);
    write_reg(wpf_pkg::REG_OFFSET_X, 16'd4000);
    write_reg(wpf_pkg::REG_OFFSET_Y, 16'd4000);
    write_reg(wpf_pkg::REG_FILTER, 16'($urandom_range(0, 7)));
    write_reg(wpf_pkg::REG_DST_WIDTH, 16'd8191);
    write_reg(wpf_pkg::REG_DST_HEIGHT, 16'd0);
    repeat (20) send_random_pixel();
    write_reg(wpf_pkg::REG_OFFSET_X, 16'd0);
    write_reg(wpf_pkg::REG_OFFSET_Y, 16'd4100);
    write_reg(wpf_pkg::REG_DST_WIDTH, 16'd1);
    write_reg(wpf_pkg::REG_DST_HEIGHT, 16'd4096);
    repeat (20) send_random_pixel();
    phases_run += 2;

    wait_pipeline_empty();
    $display("Checked %0d pixels over %0d configuration phases and all eight modes,",
             sb.checked, phases_run + 1);
    $display("%0d in bounds, %0d frame ends, %0d errors.",
             sb.in_bounds_seen, sb.frame_ends, sb.errors);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", sb.pending_pixels.size());
    $display("FAILURE");
    $finish;
  end

endmodule
